// ----- hw/rtl/tlik_pkg.sv -----
// shared constants, types and arithmetic helpers of the two-link inverse kinematics unit
package tlik_pkg;

	localparam int COORD_FRAC_BITS = 12;
	localparam int ANGLE_BITS      = 16;
	localparam int CORDIC_STAGES   = 16;

	localparam int IN_W       = 24;
	localparam int LINK_W     = 22;
	localparam int LINK_RESET = 1 << COORD_FRAC_BITS;

	localparam int R2_W  = 2 * IN_W;
	localparam int NUM_W = R2_W + 1;
	localparam int DEN_W = 2 * LINK_W + 1;

	localparam int C_FRAC    = 30;
	localparam int C_W       = C_FRAC + 2;
	localparam int CMAG_W    = C_FRAC + 1;
	localparam int DIV_STEPS = C_FRAC;

	localparam int SQRT_STEPS = 32;
	localparam int SQ_IDX_W   = $clog2(SQRT_STEPS);
	localparam int SQ_VW      = 2 * C_FRAC + 1;
	localparam int SQ_SW      = SQ_VW + 2;

	localparam int PRE_BITS   = 20;
	localparam int CW         = C_W + PRE_BITS + 2;
	localparam int ZW         = 34;
	localparam int PI_BITS    = 31;
	localparam int CIDX_W     = 5;
	localparam int ZSH        = 32 - ANGLE_BITS;
	localparam int UW         = ZW - ZSH;
	localparam int UWP        = UW + 1;
	localparam int AW         = ANGLE_BITS + 1;
	localparam int ANGLE_HALF = 1 << (ANGLE_BITS - 1);

	localparam logic signed [ZW-1:0] PI_Z = ZW'(1) << PI_BITS;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_EXCL  = 2'd2;
	localparam logic [1:0] ST_FAR   = 2'd3;

	localparam logic REG_UPPER = 1'b0;
	localparam logic REG_LOWER = 1'b1;

	typedef struct packed {
		logic [1:0]               status;
		logic                     neg;
		logic                     sat;
		logic signed [IN_W-1:0]   x;
		logic signed [IN_W-1:0]   y;
		logic signed [C_W-1:0]    c;
		logic [CMAG_W-1:0]        cmag;
	} tag_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cstate_t;

	// atan(2^-i), pi = 2^31
	function automatic logic signed [ZW-1:0] atan_step(input logic [CIDX_W-1:0] i);
		case (i)
			5'd0:  return ZW'(536870912);
			5'd1:  return ZW'(316933406);
			5'd2:  return ZW'(167458907);
			5'd3:  return ZW'(85004756);
			5'd4:  return ZW'(42667331);
			5'd5:  return ZW'(21354465);
			5'd6:  return ZW'(10679838);
			5'd7:  return ZW'(5340245);
			5'd8:  return ZW'(2670163);
			5'd9:  return ZW'(1335087);
			5'd10: return ZW'(667544);
			5'd11: return ZW'(333772);
			5'd12: return ZW'(166886);
			5'd13: return ZW'(83443);
			5'd14: return ZW'(41722);
			5'd15: return ZW'(20861);
			5'd16: return ZW'(10430);
			5'd17: return ZW'(5215);
			5'd18: return ZW'(2608);
			5'd19: return ZW'(1304);
			5'd20: return ZW'(652);
			5'd21: return ZW'(326);
			5'd22: return ZW'(163);
			5'd23: return ZW'(81);
			default: return '0;
		endcase
	endfunction

	// fold the left half plane by pi, then prescale
	function automatic cstate_t cordic_init(input logic signed [C_W-1:0] xo,
			input logic signed [C_W-1:0] yo);
		cstate_t r;
		logic signed [C_W-1:0] xa;
		logic signed [C_W-1:0] ya;
		xa = xo;
		ya = yo;
		r.z = '0;
		if (xo < 0) begin
			r.z = (yo < 0) ? -PI_Z : PI_Z;
			xa = -xo;
			ya = -yo;
		end
		r.x = CW'(xa) <<< PRE_BITS;
		r.y = CW'(ya) <<< PRE_BITS;
		return r;
	endfunction

	// round half up to output angle units
	function automatic logic signed [UW-1:0] to_units(input logic signed [ZW-1:0] z);
		logic signed [ZW-1:0] t;
		t = z + ZW'(1 << (ZSH - 1));
		return UW'(t >>> ZSH);
	endfunction

	function automatic logic signed [AW-1:0] wrap_angle(input logic signed [UWP-1:0] a);
		logic signed [UWP-1:0] r;
		r = a;
		if (a < -ANGLE_HALF) begin
			r = UWP'(a + 2 * ANGLE_HALF);
		end else if (a > ANGLE_HALF) begin
			r = UWP'(a - 2 * ANGLE_HALF);
		end
		return AW'(r);
	endfunction

endpackage

// ----- hw/rtl/tlik_div_cell.sv -----
// one restoring divide step of the elbow cosine divider
module tlik_div_cell import tlik_pkg::*; (
	input  logic              clk,
	input  logic [DEN_W-1:0]  den,
	input  logic [DEN_W-1:0]  rem_i,
	input  logic [C_FRAC-1:0] q_i,
	input  tag_t              tag_i,
	output logic [DEN_W-1:0]  rem_o,
	output logic [C_FRAC-1:0] q_o,
	output tag_t              tag_o
);

	logic [DEN_W:0] sh_w;
	logic [DEN_W:0] dif_w;
	logic           ge_w;

	assign sh_w  = {rem_i, 1'b0};
	assign ge_w  = sh_w >= {1'b0, den};
	assign dif_w = sh_w - {1'b0, den};

	always_ff @(posedge clk) begin
		rem_o <= ge_w ? dif_w[DEN_W-1:0] : sh_w[DEN_W-1:0];
		q_o   <= {q_i[C_FRAC-2:0], ge_w};
		tag_o <= tag_i;
	end

endmodule

// ----- hw/rtl/tlik_sqrt_cell.sv -----
// one digit step of the integer square root
module tlik_sqrt_cell import tlik_pkg::*; (
	input  logic                clk,
	input  logic [SQ_IDX_W-1:0] idx,
	input  logic [SQ_VW-1:0]    v_i,
	input  logic [SQ_VW-1:0]    res_i,
	input  tag_t                tag_i,
	output logic [SQ_VW-1:0]    v_o,
	output logic [SQ_VW-1:0]    res_o,
	output tag_t                tag_o
);

	logic [SQ_IDX_W:0] sh_w;
	logic [SQ_SW-1:0]  step_w;
	logic [SQ_SW-1:0]  sum_w;
	logic              ge_w;

	assign sh_w   = (SQ_IDX_W + 1)'(2 * (SQRT_STEPS - 1)) - {idx, 1'b0};
	assign step_w = SQ_SW'(1) << sh_w;
	assign sum_w  = {2'b0, res_i} + step_w;
	assign ge_w   = {2'b0, v_i} >= sum_w;

	always_ff @(posedge clk) begin
		if (ge_w) begin
			v_o   <= v_i - sum_w[SQ_VW-1:0];
			res_o <= SQ_VW'(({2'b0, res_i} >> 1) + step_w);
		end else begin
			v_o   <= v_i;
			res_o <= res_i >> 1;
		end
		tag_o <= tag_i;
	end

endmodule

// ----- hw/rtl/tlik_cordic_cell.sv -----
// one vectoring rotation of the atan2 cordic
module tlik_cordic_cell import tlik_pkg::*; (
	input  logic              clk,
	input  logic [CIDX_W-1:0] idx,
	input  cstate_t           st_i,
	output cstate_t           st_o
);

	logic signed [CW-1:0] dx_w;
	logic signed [CW-1:0] dy_w;

	assign dx_w = st_i.y >>> idx;
	assign dy_w = st_i.x >>> idx;

	always_ff @(posedge clk) begin
		if (st_i.y > 0) begin
			st_o.x <= st_i.x + dx_w;
			st_o.y <= st_i.y - dy_w;
			st_o.z <= st_i.z + atan_step(idx);
		end else if (st_i.y < 0) begin
			st_o.x <= st_i.x - dx_w;
			st_o.y <= st_i.y + dy_w;
			st_o.z <= st_i.z - atan_step(idx);
		end else begin
			st_o <= st_i;
		end
	end

endmodule

// ----- hw/rtl/two_link_inverse_kinematics_unit.sv -----
// top level of the two-link planar inverse kinematics unit
//
//  channel   signals                                        direction
//  command   start, busy, target_x, target_y, target_z      in (busy out)
//  result    done, shoulder_angle, elbow_angle, status      out
//  config    cfg_we, cfg_addr, cfg_wdata                    in
//
// one target per cycle, busy stays low; a target passes from start to done through
// the front end, the 30-cell divider, the 32-cell square root and the 16-cell
// cordic rows
// arst_n clears the link lengths to 1.0 and drops every transaction in flight
// done is a one-cycle strobe; results cannot be held off
module two_link_inverse_kinematics_unit import tlik_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [IN_W-1:0] target_x,
	input  logic signed [IN_W-1:0] target_y,
	input  logic signed [IN_W-1:0] target_z,
	input  logic                   cfg_we,
	input  logic                   cfg_addr,
	input  logic [LINK_W-1:0]      cfg_wdata,
	output logic                   done,
	output logic signed [AW-1:0]   shoulder_angle,
	output logic [ANGLE_BITS-1:0]  elbow_angle,
	output logic [1:0]             status
);

	localparam int LAT = 6 + DIV_STEPS + 3 + SQRT_STEPS + 3 + CORDIC_STAGES + 2;
	localparam logic [SQ_VW-1:0] ONE_SQ = SQ_VW'(1) << (2 * C_FRAC);

	logic [LINK_W-1:0]     l1_q;
	logic [LINK_W-1:0]     l2_q;
	logic [LINK_W-1:0]     dl_q;
	logic [LINK_W:0]       sl_q;
	logic [2*LINK_W-1:0]   dlsq_q;
	logic [2*LINK_W+1:0]   slsq_q;
	logic [2*LINK_W-1:0]   l1sq_q;
	logic [2*LINK_W-1:0]   l2sq_q;
	logic [2*LINK_W:0]     llsum_q;
	logic [DEN_W-1:0]      den_q;
	logic [2*LINK_W-1:0]   l12_w;

	logic [LAT-1:0]        vld_q;

	logic signed [IN_W-1:0] x_s1, y_s1, z_s1;
	logic signed [R2_W-1:0] xsq_w, ysq_w;
	logic [R2_W-2:0]        xsq_s2, ysq_s2;
	logic signed [IN_W-1:0] x_s2, y_s2;
	logic                   zero_s2;
	logic [R2_W-1:0]        r2_s3;
	logic signed [IN_W-1:0] x_s3, y_s3;
	logic                   zero_s3, xneg_s3;
	logic signed [NUM_W-1:0] num_s4;
	tag_t                   tag_s4;
	logic [R2_W-1:0]        mag_s5;
	tag_t                   tag_s5;
	logic [DEN_W-1:0]       rem_s6;
	tag_t                   tag_s6;
	tag_t                   tag5_w, tag6_w, tag37_w;

	logic [DEN_W-1:0]       div_rem [0:DIV_STEPS];
	logic [C_FRAC-1:0]      div_q   [0:DIV_STEPS];
	tag_t                   div_tag [0:DIV_STEPS];

	logic [CMAG_W-1:0]      cmag_w;
	logic signed [C_W-1:0]  c_w;
	tag_t                   tag_s37;
	logic [2*CMAG_W-1:0]    cc_s38;
	tag_t                   tag_s38;
	logic [SQ_VW-1:0]       v_s39;
	tag_t                   tag_s39;

	logic [SQ_VW-1:0]       sq_v   [0:SQRT_STEPS];
	logic [SQ_VW-1:0]       sq_res [0:SQRT_STEPS];
	tag_t                   sq_tag [0:SQRT_STEPS];

	logic [CMAG_W-1:0]        s_w;
	logic [LINK_W+CMAG_W-1:0] mp_w, kp_w;
	logic [LINK_W:0]          m_s72, k2_s72, k2_s73;
	logic [CMAG_W-1:0]        s_s72, s_s73;
	tag_t                     tag_s72, tag_s73;
	logic signed [IN_W-1:0]   k1_s73;

	cstate_t                cyx_s74, cel_s74, ckk_s74;
	cstate_t                cyx [0:CORDIC_STAGES];
	cstate_t                cel [0:CORDIC_STAGES];
	cstate_t                ckk [0:CORDIC_STAGES];
	logic [1:0]             st_cd [0:CORDIC_STAGES];

	logic signed [AW-1:0]   el_s91;
	logic signed [UW-1:0]   uyx_s91, ukk_s91;
	logic [1:0]             st_s91;
	logic signed [UWP-1:0]  dsh_w;

	assign busy = 1'b0;
	assign done = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= LINK_W'(LINK_RESET);
			l2_q <= LINK_W'(LINK_RESET);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_UPPER: l1_q <= cfg_wdata;
				REG_LOWER: l2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	// link-derived constants
	assign l12_w = l1_q * l2_q;

	always_ff @(posedge clk) begin
		dl_q    <= (l1_q >= l2_q) ? l1_q - l2_q : l2_q - l1_q;
		sl_q    <= {1'b0, l1_q} + {1'b0, l2_q};
		dlsq_q  <= dl_q * dl_q;
		slsq_q  <= sl_q * sl_q;
		l1sq_q  <= l1_q * l1_q;
		l2sq_q  <= l2_q * l2_q;
		llsum_q <= {1'b0, l1sq_q} + {1'b0, l2sq_q};
		den_q   <= {l12_w, 1'b0};
	end

	// front end: reach, range checks and cosine numerator
	assign xsq_w = x_s1 * x_s1;
	assign ysq_w = y_s1 * y_s1;

	always_comb begin
		tag5_w       = tag_s4;
		tag5_w.neg   = num_s4[NUM_W-1];
		tag6_w       = tag_s5;
		tag6_w.sat   = mag_s5 >= R2_W'(den_q);
		tag37_w      = div_tag[DIV_STEPS];
		tag37_w.c    = c_w;
		tag37_w.cmag = cmag_w;
	end

	always_ff @(posedge clk) begin
		x_s1 <= target_x;
		y_s1 <= target_y;
		z_s1 <= target_z;

		xsq_s2  <= xsq_w[R2_W-2:0];
		ysq_s2  <= ysq_w[R2_W-2:0];
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		zero_s2 <= (x_s1 == '0) && (y_s1 == '0) && (z_s1 == '0);

		r2_s3   <= {1'b0, xsq_s2} + {1'b0, ysq_s2};
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		zero_s3 <= zero_s2;
		xneg_s3 <= x_s2[IN_W-1];

		num_s4      <= signed'({1'b0, r2_s3}) - signed'({4'b0, llsum_q});
		tag_s4.x    <= x_s3;
		tag_s4.y    <= y_s3;
		tag_s4.neg  <= 1'b0;
		tag_s4.sat  <= 1'b0;
		tag_s4.c    <= '0;
		tag_s4.cmag <= '0;
		if (zero_s3) begin
			tag_s4.status <= ST_EMPTY;
		end else if (xneg_s3 || r2_s3 < R2_W'(dlsq_q)) begin
			tag_s4.status <= ST_EXCL;
		end else if (r2_s3 > R2_W'(slsq_q)) begin
			tag_s4.status <= ST_FAR;
		end else begin
			tag_s4.status <= ST_OK;
		end

		mag_s5 <= num_s4[NUM_W-1] ? R2_W'(-num_s4) : num_s4[R2_W-1:0];
		tag_s5 <= tag5_w;

		rem_s6 <= mag_s5[DEN_W-1:0];
		tag_s6 <= tag6_w;
	end

	// cosine divider row
	assign div_rem[0] = rem_s6;
	assign div_q[0]   = '0;
	assign div_tag[0] = tag_s6;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		tlik_div_cell u_cell (
			.clk   (clk),
			.den   (den_q),
			.rem_i (div_rem[k]),
			.q_i   (div_q[k]),
			.tag_i (div_tag[k]),
			.rem_o (div_rem[k+1]),
			.q_o   (div_q[k+1]),
			.tag_o (div_tag[k+1])
		);
	end

	assign cmag_w = div_tag[DIV_STEPS].sat ? (CMAG_W'(1) << C_FRAC)
		: {1'b0, div_q[DIV_STEPS]};
	assign c_w = div_tag[DIV_STEPS].neg ? -C_W'(cmag_w) : C_W'(cmag_w);

	always_ff @(posedge clk) begin
		tag_s37 <= tag37_w;

		cc_s38  <= tag_s37.cmag * tag_s37.cmag;
		tag_s38 <= tag_s37;

		v_s39   <= ONE_SQ - cc_s38[SQ_VW-1:0];
		tag_s39 <= tag_s38;
	end

	// sine square root row
	assign sq_v[0]   = v_s39;
	assign sq_res[0] = '0;
	assign sq_tag[0] = tag_s39;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		tlik_sqrt_cell u_cell (
			.clk   (clk),
			.idx   (SQ_IDX_W'(k)),
			.v_i   (sq_v[k]),
			.res_i (sq_res[k]),
			.tag_i (sq_tag[k]),
			.v_o   (sq_v[k+1]),
			.res_o (sq_res[k+1]),
			.tag_o (sq_tag[k+1])
		);
	end

	assign s_w  = sq_res[SQRT_STEPS][CMAG_W-1:0];
	assign mp_w = l2_q * sq_tag[SQRT_STEPS].cmag;
	assign kp_w = l2_q * s_w;

	always_ff @(posedge clk) begin
		m_s72   <= mp_w[LINK_W+CMAG_W-1:C_FRAC];
		k2_s72  <= kp_w[LINK_W+CMAG_W-1:C_FRAC];
		s_s72   <= s_w;
		tag_s72 <= sq_tag[SQRT_STEPS];

		k1_s73  <= tag_s72.c[C_W-1] ? IN_W'({1'b0, l1_q}) - IN_W'(m_s72)
			: IN_W'({1'b0, l1_q}) + IN_W'(m_s72);
		k2_s73  <= k2_s72;
		s_s73   <= s_s72;
		tag_s73 <= tag_s72;

		cyx_s74 <= cordic_init(C_W'(tag_s73.x), C_W'(tag_s73.y));
		cel_s74 <= cordic_init(tag_s73.c, C_W'(s_s73));
		ckk_s74 <= cordic_init(C_W'(k1_s73), C_W'(k2_s73));
		st_cd[0] <= tag_s73.status;
		for (int k = 0; k < CORDIC_STAGES; k++) begin
			st_cd[k+1] <= st_cd[k];
		end
	end

	// three cordic rows side by side
	assign cyx[0] = cyx_s74;
	assign cel[0] = cel_s74;
	assign ckk[0] = ckk_s74;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		tlik_cordic_cell u_yx (
			.clk  (clk),
			.idx  (CIDX_W'(k)),
			.st_i (cyx[k]),
			.st_o (cyx[k+1])
		);
		tlik_cordic_cell u_el (
			.clk  (clk),
			.idx  (CIDX_W'(k)),
			.st_i (cel[k]),
			.st_o (cel[k+1])
		);
		tlik_cordic_cell u_kk (
			.clk  (clk),
			.idx  (CIDX_W'(k)),
			.st_i (ckk[k]),
			.st_o (ckk[k+1])
		);
	end

	assign dsh_w = UWP'(uyx_s91) - UWP'(ukk_s91);

	always_ff @(posedge clk) begin
		el_s91  <= wrap_angle(UWP'(to_units(cel[CORDIC_STAGES].z)));
		uyx_s91 <= to_units(cyx[CORDIC_STAGES].z);
		ukk_s91 <= to_units(ckk[CORDIC_STAGES].z);
		st_s91  <= st_cd[CORDIC_STAGES];

		status <= st_s91;
		if (st_s91 != ST_OK) begin
			shoulder_angle <= '0;
			elbow_angle    <= '0;
		end else begin
			shoulder_angle <= wrap_angle(dsh_w);
			elbow_angle    <= el_s91[ANGLE_BITS-1:0];
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result strobe missing after fixed latency");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> shoulder_angle == '0 && elbow_angle == '0)
		else $error("angles not cleared on error status");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $signed(shoulder_angle) <= ANGLE_HALF
			&& $signed(shoulder_angle) >= -ANGLE_HALF
			&& elbow_angle <= ANGLE_BITS'(ANGLE_HALF))
		else $error("angle outside [-pi, pi]");

endmodule
